FILE: design/trg_pkg.sv
// shared constants, types and command codes for the transient restorer gain block
// no dependencies
package trg_pkg;

  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 24;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int COEF_W  = 25;
  localparam int GAIN_W  = 24;
  localparam int RATIO_W = 24;
  localparam int ENV_W   = SAMPLE_BITS;
  localparam int DIV_W   = (SAMPLE_BITS > 24) ? SAMPLE_BITS : 24;
  localparam int CNT_W   = 5;
  localparam int MA_W    = 26;
  localparam int MB_W    = (SAMPLE_BITS > 26) ? SAMPLE_BITS : 26;
  localparam int P_W     = MA_W + MB_W;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 25;

  localparam logic [COEF_W-1:0] ONE_Q24 = 25'h100_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRANSIENT_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_DECAY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_RATIO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_RATIO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_ATTACK    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM         = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_RELEASE   = 3'd7;

  localparam logic [GAIN_W-1:0]  RST_TRANSIENT_GAIN = 24'd1048576;
  localparam logic [GAIN_W-1:0]  RST_TAIL_GAIN      = 24'd1048576;
  localparam logic [COEF_W-1:0]  RST_MASK_DECAY     = 25'd0;
  localparam logic [RATIO_W-1:0] RST_LOWER_RATIO    = 24'd131072;
  localparam logic [RATIO_W-1:0] RST_UPPER_RATIO    = 24'd131072;
  localparam logic [COEF_W-1:0]  RST_FAST_ATTACK    = 25'd777000;
  localparam logic [COEF_W-1:0]  RST_MEDIUM         = 25'd37952;
  localparam logic [COEF_W-1:0]  RST_SLOW_RELEASE   = 25'd7605;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_MUL_FAST,
    CMD_UPD_FAST,
    CMD_MUL_SLOW,
    CMD_UPD_SLOW,
    CMD_DIV1_INIT,
    CMD_DIV_STEP,
    CMD_DIV1_END,
    CMD_DIV2_INIT,
    CMD_DIV2_END,
    CMD_MUL_X2,
    CMD_UPD_X2,
    CMD_MUL_AMT,
    CMD_UPD_AMT,
    CMD_MUL_DECAY,
    CMD_UPD_MASK,
    CMD_MUL_TAIL,
    CMD_ACC_TAIL,
    CMD_MUL_TRANS,
    CMD_ACC_TRANS,
    CMD_MUL_OUT,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    logic pass;
    logic div_last;
  } status_t;

endpackage

FILE: design/transient_restorer_gain.sv
// Transient restorer gain, top level.
// Input channel: in_valid_i / in_stall_o carry channel_i and sample_in_i (Q1.23).
// Output channel: out_valid_o / out_stall_i carry sample_out_o (Q1.23, clipped).
// A transaction is taken when valid is high and stall is low at a clock edge.
// Channels 0 and 1 are processed; channels 2 and 3 come back unchanged, held in
// raw_q and then registered in the output register. For a processed transaction,
// a shared 26-bit multiplier is used eight times and a one-bit-per-cycle divider
// runs twice for 24 steps each before the result is registered.
// One transaction is in flight at a time; the next is accepted once the result
// has moved into the output register.
// If the receiver stalls, the result holds in the output register and the block
// waits before loading the next result; the input is stalled meanwhile.
// Configuration writes via cfg_we_i, cfg_index_i and cfg_data_i take effect at
// the clock edge and belong in idle periods.
// Reset clears all envelopes and masks to zero, sets registers to their default
// values and empties the output register.
// depends on trg_pkg, trg_ctrl and trg_datapath
module transient_restorer_gain
  import trg_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    channel_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]              cfg_data_i
);

  cmd_e    cmd;
  status_t status;

  trg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  trg_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .channel_i    (channel_i),
    .sample_in_i  (sample_in_i),
    .sample_out_o (sample_out_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

endmodule

FILE: design/trg_datapath.sv
// datapath: config registers, channel state, shared multiplier and shift-subtract divider
// depends on trg_pkg
module trg_datapath
  import trg_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmd_e                          cmd_i,
  output status_t                       status_o,
  input  logic [1:0]                    channel_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]              cfg_data_i
);

  logic [GAIN_W-1:0]  trans_gain_q, tail_gain_q;
  logic [COEF_W-1:0]  decay_q, fast_att_q, medium_q, slow_rel_q;
  logic [RATIO_W-1:0] lower_q, upper_q;

  logic [ENV_W-1:0]  fast_mem_q [CHANNELS];
  logic [ENV_W-1:0]  slow_mem_q [CHANNELS];
  logic [COEF_W-1:0] mask_mem_q [CHANNELS];

  logic [CH_W-1:0]        ch_q;
  logic [SAMPLE_BITS-1:0] raw_q, mag_q;
  logic                   neg_q, pass_q, up_q;
  logic [ENV_W-1:0]       fast_q, slow_q;
  logic [COEF_W-1:0]      mask_q, x_q, x2_q, held_q;
  logic [RATIO_W-1:0]     ratio_q;
  logic                   sat_q, floor_q, range_ok_q, lo_q, hi_q;
  logic [GAIN_W-1:0]      gain_q;
  logic [P_W-1:0]         p_q, acc_q;
  logic [SAMPLE_BITS-1:0] out_q;

  logic [DIV_W-1:0] rem_q, den_q;
  logic [23:0]      sh_q, quo_q;
  logic [CNT_W-1:0] cnt_q;

  logic [MA_W-1:0]  a_sel;
  logic [MB_W-1:0]  b_sel;
  logic [P_W-1:0]   rnd;
  logic [DIV_W:0]   trial;
  logic [SAMPLE_BITS-1:0] mag_in;
  logic [ENV_W-1:0] den1;
  logic [COEF_W-1:0] amt;
  logic [P_W-1:0]   gsum, oprod;
  logic [SAMPLE_BITS-1:0] res;

  function automatic logic [COEF_W-1:0] coef_sat(input logic [COEF_W-1:0] c);
    return (c > ONE_Q24) ? ONE_Q24 : c;
  endfunction

  assign mag_in = sample_in_i[SAMPLE_BITS-1] ? (~sample_in_i + 1'b1) : sample_in_i;
  assign rnd    = (p_q + P_W'(24'h80_0000)) >> 24;
  assign trial  = {rem_q, sh_q[23]};
  assign den1   = (slow_q > ENV_W'(8)) ? slow_q : ENV_W'(8);
  assign amt    = (rnd > P_W'(ONE_Q24)) ? ONE_Q24 : rnd[COEF_W-1:0];
  assign gsum   = (acc_q + p_q + P_W'(24'h80_0000)) >> 24;
  assign oprod  = (p_q + P_W'(20'h8_0000)) >> 20;

  assign status_o.pass     = ({3'b000, channel_i} >= 5'(CHANNELS));
  assign status_o.div_last = (cnt_q == CNT_W'(23));

  // multiplier operand selection
  always_comb begin
    a_sel = '0;
    b_sel = '0;
    case (cmd_i)
      CMD_MUL_FAST: begin
        a_sel = MA_W'(coef_sat(up_q ? fast_att_q : medium_q));
        b_sel = MB_W'(up_q ? (mag_q - fast_q) : (fast_q - mag_q));
      end
      CMD_MUL_SLOW: begin
        a_sel = MA_W'(coef_sat(up_q ? medium_q : slow_rel_q));
        b_sel = MB_W'(up_q ? (mag_q - slow_q) : (slow_q - mag_q));
      end
      CMD_MUL_X2: begin
        a_sel = MA_W'(x_q);
        b_sel = MB_W'(x_q);
      end
      CMD_MUL_AMT: begin
        a_sel = MA_W'(x2_q);
        b_sel = MB_W'(26'h300_0000 - {x_q, 1'b0});
      end
      CMD_MUL_DECAY: begin
        a_sel = MA_W'(held_q);
        b_sel = MB_W'(coef_sat(decay_q));
      end
      CMD_MUL_TAIL: begin
        a_sel = MA_W'(ONE_Q24 - held_q);
        b_sel = MB_W'(tail_gain_q);
      end
      CMD_MUL_TRANS: begin
        a_sel = MA_W'(held_q);
        b_sel = MB_W'(trans_gain_q);
      end
      CMD_MUL_OUT: begin
        a_sel = MA_W'(gain_q);
        b_sel = MB_W'(mag_q);
      end
      default: ;
    endcase
  end

  // output clip and sign restore; pass-through channels take the raw sample
  always_comb begin
    if (pass_q) begin
      res = raw_q;
    end else if (neg_q) begin
      if (oprod > P_W'({1'b1, {(SAMPLE_BITS-1){1'b0}}})) begin
        res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
        res = ~oprod[SAMPLE_BITS-1:0] + 1'b1;
      end
    end else begin
      if (oprod > P_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}})) begin
        res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
        res = oprod[SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_gain_q <= RST_TRANSIENT_GAIN;
      tail_gain_q  <= RST_TAIL_GAIN;
      decay_q      <= RST_MASK_DECAY;
      lower_q      <= RST_LOWER_RATIO;
      upper_q      <= RST_UPPER_RATIO;
      fast_att_q   <= RST_FAST_ATTACK;
      medium_q     <= RST_MEDIUM;
      slow_rel_q   <= RST_SLOW_RELEASE;
      for (int i = 0; i < CHANNELS; i++) begin
        fast_mem_q[i] <= '0;
        slow_mem_q[i] <= '0;
        mask_mem_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TRANSIENT_GAIN: trans_gain_q <= cfg_data_i[GAIN_W-1:0];
          REG_TAIL_GAIN:      tail_gain_q  <= cfg_data_i[GAIN_W-1:0];
          REG_MASK_DECAY:     decay_q      <= cfg_data_i;
          REG_LOWER_RATIO:    lower_q      <= cfg_data_i[RATIO_W-1:0];
          REG_UPPER_RATIO:    upper_q      <= cfg_data_i[RATIO_W-1:0];
          REG_FAST_ATTACK:    fast_att_q   <= cfg_data_i;
          REG_MEDIUM:         medium_q     <= cfg_data_i;
          REG_SLOW_RELEASE:   slow_rel_q   <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i)
        CMD_UPD_FAST: fast_mem_q[ch_q] <= up_q ? fast_q + rnd[ENV_W-1:0]
                                               : fast_q - rnd[ENV_W-1:0];
        CMD_UPD_SLOW: slow_mem_q[ch_q] <= up_q ? slow_q + rnd[ENV_W-1:0]
                                               : slow_q - rnd[ENV_W-1:0];
        CMD_UPD_MASK: mask_mem_q[ch_q] <= rnd[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    // product holds while the result waits on a stalled receiver
    if (cmd_i != CMD_NOP) begin
      p_q <= a_sel * b_sel;
    end
    case (cmd_i)
      CMD_LOAD: begin
        ch_q   <= CH_W'(channel_i);
        pass_q <= status_o.pass;
        raw_q  <= sample_in_i;
        neg_q  <= sample_in_i[SAMPLE_BITS-1];
        mag_q  <= mag_in;
        fast_q <= fast_mem_q[CH_W'(channel_i)];
        slow_q <= slow_mem_q[CH_W'(channel_i)];
        mask_q <= mask_mem_q[CH_W'(channel_i)];
        up_q   <= mag_in > fast_mem_q[CH_W'(channel_i)];
      end
      CMD_UPD_FAST: begin
        fast_q <= up_q ? fast_q + rnd[ENV_W-1:0] : fast_q - rnd[ENV_W-1:0];
        up_q   <= mag_q > slow_q;
      end
      CMD_UPD_SLOW: slow_q <= up_q ? slow_q + rnd[ENV_W-1:0] : slow_q - rnd[ENV_W-1:0];
      CMD_DIV1_INIT: begin
        // quotient overflows 24 bits when the top dividend bits reach the divisor
        floor_q <= fast_q <= ENV_W'(8);
        sat_q   <= DIV_W'(fast_q >> 8) >= DIV_W'(den1);
        rem_q   <= DIV_W'(fast_q >> 8);
        den_q   <= DIV_W'(den1);
        sh_q    <= {fast_q[7:0], 16'h0000};
        cnt_q   <= '0;
      end
      CMD_DIV_STEP: begin
        if (trial >= {1'b0, den_q}) begin
          rem_q <= DIV_W'(trial - {1'b0, den_q});
          quo_q <= {quo_q[22:0], 1'b1};
        end else begin
          rem_q <= trial[DIV_W-1:0];
          quo_q <= {quo_q[22:0], 1'b0};
        end
        sh_q  <= {sh_q[22:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
      end
      CMD_DIV1_END: ratio_q <= floor_q ? '0 : (sat_q ? {RATIO_W{1'b1}} : quo_q);
      CMD_DIV2_INIT: begin
        range_ok_q <= upper_q > lower_q;
        lo_q       <= ratio_q <= lower_q;
        hi_q       <= ratio_q >= upper_q;
        rem_q      <= DIV_W'(ratio_q - lower_q);
        den_q      <= DIV_W'(upper_q - lower_q);
        sh_q       <= '0;
        cnt_q      <= '0;
      end
      CMD_DIV2_END: begin
        if (!range_ok_q || lo_q) begin
          x_q <= '0;
        end else if (hi_q) begin
          x_q <= ONE_Q24;
        end else begin
          x_q <= {1'b0, quo_q};
        end
      end
      CMD_UPD_X2:    x2_q   <= rnd[COEF_W-1:0];
      CMD_UPD_AMT:   held_q <= (amt > mask_q) ? amt : mask_q;
      CMD_ACC_TAIL:  acc_q  <= p_q;
      CMD_ACC_TRANS: gain_q <= gsum[GAIN_W-1:0];
      CMD_OUT:       out_q  <= res;
      default: ;
    endcase
  end

  assign sample_out_o = out_q;

endmodule

FILE: design/trg_ctrl.sv
// controller: sequences one transaction through the datapath and owns both handshakes
// depends on trg_pkg
module trg_ctrl
  import trg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_e    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_FAST, S_UPD_FAST, S_MUL_SLOW, S_UPD_SLOW,
    S_DIV1_INIT, S_DIV1, S_DIV1_END, S_DIV2_INIT, S_DIV2, S_DIV2_END,
    S_MUL_X2, S_UPD_X2, S_MUL_AMT, S_UPD_AMT, S_MUL_DECAY, S_UPD_MASK,
    S_MUL_TAIL, S_ACC_TAIL, S_MUL_TRANS, S_ACC_TRANS, S_MUL_OUT, S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept, emit;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = (state_q == S_IDLE) && in_valid_i;
  assign emit        = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    case (state_q)
      S_IDLE:      cmd_o = accept ? CMD_LOAD : CMD_NOP;
      S_MUL_FAST:  cmd_o = CMD_MUL_FAST;
      S_UPD_FAST:  cmd_o = CMD_UPD_FAST;
      S_MUL_SLOW:  cmd_o = CMD_MUL_SLOW;
      S_UPD_SLOW:  cmd_o = CMD_UPD_SLOW;
      S_DIV1_INIT: cmd_o = CMD_DIV1_INIT;
      S_DIV1:      cmd_o = CMD_DIV_STEP;
      S_DIV1_END:  cmd_o = CMD_DIV1_END;
      S_DIV2_INIT: cmd_o = CMD_DIV2_INIT;
      S_DIV2:      cmd_o = CMD_DIV_STEP;
      S_DIV2_END:  cmd_o = CMD_DIV2_END;
      S_MUL_X2:    cmd_o = CMD_MUL_X2;
      S_UPD_X2:    cmd_o = CMD_UPD_X2;
      S_MUL_AMT:   cmd_o = CMD_MUL_AMT;
      S_UPD_AMT:   cmd_o = CMD_UPD_AMT;
      S_MUL_DECAY: cmd_o = CMD_MUL_DECAY;
      S_UPD_MASK:  cmd_o = CMD_UPD_MASK;
      S_MUL_TAIL:  cmd_o = CMD_MUL_TAIL;
      S_ACC_TAIL:  cmd_o = CMD_ACC_TAIL;
      S_MUL_TRANS: cmd_o = CMD_MUL_TRANS;
      S_ACC_TRANS: cmd_o = CMD_ACC_TRANS;
      S_MUL_OUT:   cmd_o = CMD_MUL_OUT;
      S_OUT:       cmd_o = emit ? CMD_OUT : CMD_NOP;
      default:     cmd_o = CMD_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE:      if (accept) state_q <= status_i.pass ? S_OUT : S_MUL_FAST;
        S_MUL_FAST:  state_q <= S_UPD_FAST;
        S_UPD_FAST:  state_q <= S_MUL_SLOW;
        S_MUL_SLOW:  state_q <= S_UPD_SLOW;
        S_UPD_SLOW:  state_q <= S_DIV1_INIT;
        S_DIV1_INIT: state_q <= S_DIV1;
        S_DIV1:      if (status_i.div_last) state_q <= S_DIV1_END;
        S_DIV1_END:  state_q <= S_DIV2_INIT;
        S_DIV2_INIT: state_q <= S_DIV2;
        S_DIV2:      if (status_i.div_last) state_q <= S_DIV2_END;
        S_DIV2_END:  state_q <= S_MUL_X2;
        S_MUL_X2:    state_q <= S_UPD_X2;
        S_UPD_X2:    state_q <= S_MUL_AMT;
        S_MUL_AMT:   state_q <= S_UPD_AMT;
        S_UPD_AMT:   state_q <= S_MUL_DECAY;
        S_MUL_DECAY: state_q <= S_UPD_MASK;
        S_UPD_MASK:  state_q <= S_MUL_TAIL;
        S_MUL_TAIL:  state_q <= S_ACC_TAIL;
        S_ACC_TAIL:  state_q <= S_MUL_TRANS;
        S_MUL_TRANS: state_q <= S_ACC_TRANS;
        S_ACC_TRANS: state_q <= S_MUL_OUT;
        S_MUL_OUT:   state_q <= S_OUT;
        S_OUT:       if (emit) state_q <= S_IDLE;
        default:     state_q <= S_IDLE;
      endcase
    end
  end

endmodule
